// ===== sv/alpe_pkg.sv =====
// Shared types and constants for the addressable LED pulse encoder.
package alpe_pkg;

	localparam int DurWidth       = 15;
	localparam int ColorWidth     = 8;
	localparam int PulsesPerPixel = 3 * ColorWidth;
	localparam int PulseCntWidth  = $clog2(PulsesPerPixel);
	localparam int CfgIdxWidth    = 3;

	// Register map of the configuration port
	typedef enum logic [CfgIdxWidth-1:0] {
		REG_ZERO_HIGH = 3'd0,
		REG_ZERO_LOW  = 3'd1,
		REG_ONE_HIGH  = 3'd2,
		REG_ONE_LOW   = 3'd3,
		REG_RESET     = 3'd4
	} cfg_reg_t;

	localparam logic [DurWidth-1:0] ZeroHighRst = DurWidth'(7);
	localparam logic [DurWidth-1:0] ZeroLowRst  = DurWidth'(16);
	localparam logic [DurWidth-1:0] OneHighRst  = DurWidth'(14);
	localparam logic [DurWidth-1:0] OneLowRst   = DurWidth'(12);
	localparam logic [DurWidth-1:0] ResetRst    = DurWidth'(1000);

	// Timing configuration as seen by the pulse selector
	typedef struct packed {
		logic [DurWidth-1:0] zero_high;
		logic [DurWidth-1:0] zero_low;
		logic [DurWidth-1:0] one_high;
		logic [DurWidth-1:0] one_low;
		logic [DurWidth-1:0] reset_gap;
	} timing_cfg_t;

	// One pulse pair with its framing flags
	typedef struct packed {
		logic [DurWidth-1:0] high_ticks;
		logic [DurWidth-1:0] low_ticks;
		logic                end_of_pixel;
		logic                end_of_frame;
	} pulse_t;

endpackage

// ===== sv/alpe_pulse_sel.sv =====
// Pulse selector: maps one data bit and its position to a pulse pair.
module alpe_pulse_sel (
	input  logic                  data_bit,
	input  logic                  final_bit,
	input  logic                  last_pixel,
	input  alpe_pkg::timing_cfg_t cfg,
	output alpe_pkg::pulse_t      pulse
);

	logic [alpe_pkg::DurWidth-1:0] low_base;

	// Pick the bit timing
	assign low_base = data_bit ? cfg.one_low : cfg.zero_low;

	// Append the latch gap on the frame's final pulse; the add wraps at the field width
	always_comb begin
		pulse.high_ticks   = data_bit ? cfg.one_high : cfg.zero_high;
		pulse.low_ticks    = (final_bit && last_pixel) ? low_base + cfg.reset_gap : low_base;
		pulse.end_of_pixel = final_bit;
		pulse.end_of_frame = final_bit && last_pixel;
	end

endmodule

// ===== sv/addressable_led_pulse_encoder_top.sv =====
// Top level: one pixel in, 24 pulse pairs out, green-red-blue, MSB first.
// Latency: the first pulse of a pixel passes the pixel register and then the output register,
// and it leaves the pixel register only when the output register is free.
// Throughput: one pulse per cycle while out_stall is low, sustained across pixels; the pixel
// shift register sets the figure, and the next pixel loads as its 24th pulse leaves.
// Reset: arst_n clears all valid flags and returns the timing registers to
// their default values; no clearing pass is needed.
module addressable_led_pulse_encoder_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_write_en,
	input  logic [alpe_pkg::CfgIdxWidth-1:0]     cfg_index,
	input  logic [alpe_pkg::DurWidth-1:0]        cfg_data,
	// pixel channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [alpe_pkg::ColorWidth-1:0]      red,
	input  logic [alpe_pkg::ColorWidth-1:0]      green,
	input  logic [alpe_pkg::ColorWidth-1:0]      blue,
	input  logic                                 last_pixel,
	// pulse channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [alpe_pkg::DurWidth-1:0]        high_ticks,
	output logic [alpe_pkg::DurWidth-1:0]        low_ticks,
	output logic                                 end_of_pixel,
	output logic                                 end_of_frame
);

	alpe_pkg::timing_cfg_t cfg_q;

	logic [alpe_pkg::PulsesPerPixel-1:0] word_s1;
	logic                                last_s1;
	logic [alpe_pkg::PulseCntWidth-1:0]  cnt_s1;
	logic                                valid_s1;

	alpe_pkg::pulse_t pulse;
	alpe_pkg::pulse_t out_q;
	logic             out_valid_q;

	logic adv;
	logic final_bit;
	logic in_take;

	// Timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high <= alpe_pkg::ZeroHighRst;
			cfg_q.zero_low  <= alpe_pkg::ZeroLowRst;
			cfg_q.one_high  <= alpe_pkg::OneHighRst;
			cfg_q.one_low   <= alpe_pkg::OneLowRst;
			cfg_q.reset_gap <= alpe_pkg::ResetRst;
		end else if (cfg_write_en) begin
			case (cfg_index)
				alpe_pkg::REG_ZERO_HIGH: cfg_q.zero_high <= cfg_data;
				alpe_pkg::REG_ZERO_LOW:  cfg_q.zero_low  <= cfg_data;
				alpe_pkg::REG_ONE_HIGH:  cfg_q.one_high  <= cfg_data;
				alpe_pkg::REG_ONE_LOW:   cfg_q.one_low   <= cfg_data;
				alpe_pkg::REG_RESET:     cfg_q.reset_gap <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: advance when a pixel is held and the output register is free
	assign final_bit = (cnt_s1 == alpe_pkg::PulseCntWidth'(alpe_pkg::PulsesPerPixel - 1));
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !(adv && final_bit);
	assign in_take   = in_valid && !in_stall;

	// Pixel register: load, then shift one bit out per pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s1   <= '0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
			cnt_s1   <= '0;
		end else if (adv) begin
			valid_s1 <= !final_bit;
			cnt_s1   <= cnt_s1 + alpe_pkg::PulseCntWidth'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= {green, red, blue};
			last_s1 <= last_pixel;
		end else if (adv) begin
			word_s1 <= {word_s1[alpe_pkg::PulsesPerPixel-2:0], 1'b0};
		end
	end

	alpe_pulse_sel u_pulse_sel (
		.data_bit   (word_s1[alpe_pkg::PulsesPerPixel-1]),
		.final_bit  (final_bit),
		.last_pixel (last_s1),
		.cfg        (cfg_q),
		.pulse      (pulse)
	);

	// Output register: hold while stalled, drop once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= pulse;
		end
	end

	assign out_valid    = out_valid_q;
	assign high_ticks   = out_q.high_ticks;
	assign low_ticks    = out_q.low_ticks;
	assign end_of_pixel = out_q.end_of_pixel;
	assign end_of_frame = out_q.end_of_frame;

endmodule

// ===== sv/alpe_checker.sv =====
// Port-level checker for the pulse encoder, bound to the top level.
module alpe_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic end_of_pixel,
	input logic end_of_frame
);

	// A stalled pulse stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("pulse withdrawn while stalled");

	// Frame end only comes with pixel end
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> end_of_pixel)
		else $error("end_of_frame without end_of_pixel");

	// An accepted pixel is followed by an offered pulse
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("no pulse after pixel transaction");

	// A pixel taken while the output holds a stalled pulse does not directly follow another take
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && out_valid && out_stall |-> !$past(in_valid && !in_stall))
		else $error("pixel taken while previous pixel could not drain");

endmodule

bind addressable_led_pulse_encoder_top alpe_checker u_alpe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.end_of_pixel (end_of_pixel),
	.end_of_frame (end_of_frame)
);
